/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL of the downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/core/ads_pkg.sv */
`timescale 1ns / 1ps

package ads_pkg;

  // Sizing of the datapath.
  localparam int MAX_WIDTH   = 8192;
  localparam int LANES       = 4;
  localparam int SAMPLE_BITS = 16;

  // Weight units and pixel counts.
  localparam int W_W   = $clog2(MAX_WIDTH) + 1;
  localparam int CNT_W = $clog2(MAX_WIDTH);

  // Weighted sums, rounding numerator and doubled denominator.
  localparam int SUM_W = W_W + SAMPLE_BITS;
  localparam int NUM_W = SUM_W + 1;
  localparam int DEN_W = W_W + 1;

  // One quotient bit per divider step.
  localparam int DIV_CNT_W = $clog2(SAMPLE_BITS);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int SPP_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPP       = 2'd2;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [W_W-1:0]         weight_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] src_width;
    logic [CFG_DATA_W-1:0] dst_width;
    logic [SPP_W-1:0]      samples_per_pixel;
  } cfg_t;

  // One classified source pixel.
  typedef struct packed {
    sample_t [LANES-1:0] smp;     // samples, inactive lanes zeroed
    logic    [LANES-1:0] act;     // lanes active for this pixel
    weight_t             w_add;   // units that go into the current bin
    weight_t             w_rest;  // units that open the next bin
    weight_t             s;       // clamped source width
    logic                emit;    // current bin fills with this pixel
    logic                last;    // last pixel of the row
  } cmd_t;

endpackage

/* rtl/core/ads_in_if.sv */
`timescale 1ns / 1ps

// Source pixel channel.
interface ads_in_if;
  logic              valid;
  logic              ready;
  ads_pkg::sample_t  sample_0;
  ads_pkg::sample_t  sample_1;
  ads_pkg::sample_t  sample_2;
  ads_pkg::sample_t  sample_3;

  modport source (output valid, output sample_0, output sample_1, output sample_2,
                  output sample_3, input ready);
  modport sink   (input valid, input sample_0, input sample_1, input sample_2,
                  input sample_3, output ready);
endinterface

/* rtl/core/ads_out_if.sv */
`timescale 1ns / 1ps

// Averaged pixel channel.
interface ads_out_if;
  logic              valid;
  logic              ready;
  ads_pkg::sample_t  out_0;
  ads_pkg::sample_t  out_1;
  ads_pkg::sample_t  out_2;
  ads_pkg::sample_t  out_3;
  logic              row_end;

  modport source (output valid, output out_0, output out_1, output out_2,
                  output out_3, output row_end, input ready);
  modport sink   (input valid, input out_0, input out_1, input out_2,
                  input out_3, input row_end, output ready);
endinterface

/* rtl/core/ads_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes source pixels, tracks bin fill and row position, and turns each
// pixel into a command for the arithmetic back end.
module ads_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ads_pkg::cfg_t    cfg_i,
  ads_in_if.sink           pix_i,
  input  logic             q_full_i,
  output logic             push_valid_o,
  output ads_pkg::cmd_t    push_cmd_o
);

  logic [ads_pkg::W_W-1:0]   bin_fill_q, bin_fill_d;
  logic [ads_pkg::CNT_W-1:0] pixel_count_q, pixel_count_d;

  logic [ads_pkg::W_W-1:0]   s, d, part, rest;
  logic [ads_pkg::SPP_W-1:0] nl;
  logic [ads_pkg::W_W:0]     fill_sum;
  logic                      emit, last, accept;
  ads_pkg::sample_t [ads_pkg::LANES-1:0] raw;

  // Clamp the configuration to its working ranges.
  always_comb begin
    if (cfg_i.src_width == '0) begin
      s = ads_pkg::W_W'(1);
    end else if (cfg_i.src_width > ads_pkg::W_W'(ads_pkg::MAX_WIDTH)) begin
      s = ads_pkg::W_W'(ads_pkg::MAX_WIDTH);
    end else begin
      s = cfg_i.src_width;
    end
    if (cfg_i.dst_width == '0) begin
      d = ads_pkg::W_W'(1);
    end else if (cfg_i.dst_width > s) begin
      d = s;
    end else begin
      d = cfg_i.dst_width;
    end
    if (cfg_i.samples_per_pixel == '0) begin
      nl = ads_pkg::SPP_W'(1);
    end else if (cfg_i.samples_per_pixel > ads_pkg::SPP_W'(ads_pkg::LANES)) begin
      nl = ads_pkg::SPP_W'(ads_pkg::LANES);
    end else begin
      nl = cfg_i.samples_per_pixel;
    end
  end

  // Classify the pixel: does the current bin fill, and does the row end.
  always_comb begin
    fill_sum = {1'b0, bin_fill_q} + {1'b0, d};
    emit     = (fill_sum >= {1'b0, s});
    part     = (bin_fill_q >= s) ? '0 : (s - bin_fill_q);
    rest     = d - part;
    last     = (({1'b0, pixel_count_q} + ads_pkg::W_W'(1)) >= s);
  end

  assign raw[0] = pix_i.sample_0;
  assign raw[1] = pix_i.sample_1;
  assign raw[2] = pix_i.sample_2;
  assign raw[3] = pix_i.sample_3;

  // Build the command; inactive lanes carry zero.
  always_comb begin
    for (int i = 0; i < ads_pkg::LANES; i++) begin
      push_cmd_o.act[i] = (ads_pkg::SPP_W'(i) < nl);
      push_cmd_o.smp[i] = (ads_pkg::SPP_W'(i) < nl) ? raw[i] : '0;
    end
    push_cmd_o.w_add  = emit ? part : d;
    push_cmd_o.w_rest = rest;
    push_cmd_o.s      = s;
    push_cmd_o.emit   = emit;
    push_cmd_o.last   = last;
  end

  assign pix_i.ready  = !q_full_i;
  assign accept       = pix_i.valid && !q_full_i;
  assign push_valid_o = accept;

  // Next fill and row position.
  always_comb begin
    bin_fill_d    = bin_fill_q;
    pixel_count_d = pixel_count_q;
    if (accept) begin
      if (last) begin
        bin_fill_d    = '0;
        pixel_count_d = '0;
      end else begin
        bin_fill_d    = emit ? rest : fill_sum[ads_pkg::W_W-1:0];
        pixel_count_d = pixel_count_q + ads_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_fill_q    <= '0;
      pixel_count_q <= '0;
    end else begin
      bin_fill_q    <= bin_fill_d;
      pixel_count_q <= pixel_count_d;
    end
  end

  `ASSERT_AT(a_row_restart, clk_i, rst_ni, (accept && last) |=> (pixel_count_q == '0 && bin_fill_q == '0), "row did not restart after its last pixel")

endmodule

/* rtl/core/ads_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Short command queue that lets the front and back stall on their own.
module ads_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  ads_pkg::cmd_t   push_cmd_i,
  output logic            full_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ads_pkg::cmd_t   pop_cmd_o
);

  ads_pkg::cmd_t                 entry_q [ads_pkg::Q_DEPTH];
  logic [ads_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ads_pkg::Q_CNT_W-1:0]   count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o      = (count_q == ads_pkg::Q_CNT_W'(ads_pkg::Q_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_cmd_o   = entry_q[rd_ptr_q];
  assign do_push     = push_valid_i && !full_o;
  assign do_pop      = pop_ready_i && pop_valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + ads_pkg::Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + ads_pkg::Q_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + ads_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - ads_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_valid_i && full_o, "command pushed into a full queue")

endmodule

/* rtl/core/ads_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Carries out commands: weights samples, accumulates the bin sums and,
// when a bin fills, divides each lane by the bin size with rounding.
module ads_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  ads_pkg::cmd_t   pop_cmd_i,
  ads_out_if.source       pix_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_REST = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [ads_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  ads_pkg::cmd_t                   cmd_q;
  logic                            out_valid_q, out_valid_d;
  logic                            load_out;

  logic [ads_pkg::SUM_W-1:0]       partial_q [ads_pkg::LANES];
  logic [ads_pkg::SUM_W-1:0]       prod_q    [ads_pkg::LANES];
  logic [ads_pkg::DEN_W-1:0]       rem_q     [ads_pkg::LANES];
  ads_pkg::sample_t                lq_q      [ads_pkg::LANES];
  logic                            sat_q     [ads_pkg::LANES];
  ads_pkg::sample_t                res_q     [ads_pkg::LANES];
  logic                            row_end_q;

  ads_pkg::weight_t                weight;
  logic [ads_pkg::DEN_W-1:0]       den;
  logic [ads_pkg::SUM_W-1:0]       sum       [ads_pkg::LANES];
  logic [ads_pkg::NUM_W-1:0]       num       [ads_pkg::LANES];
  logic [ads_pkg::DEN_W:0]         trial     [ads_pkg::LANES];
  logic                            ge        [ads_pkg::LANES];

  assign pop_ready_o = (state_q == ST_IDLE);
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || pix_o.ready);

  // One multiplier per lane, shared between the bin share and the rest.
  assign weight = (state_q == ST_ACC) ? cmd_q.w_rest : cmd_q.w_add;
  assign den    = {cmd_q.s, 1'b0};

  // Per-lane sum, rounding numerator and one restoring divider step.
  always_comb begin
    for (int i = 0; i < ads_pkg::LANES; i++) begin
      sum[i]   = partial_q[i] + prod_q[i];
      num[i]   = {sum[i], 1'b0} + ads_pkg::NUM_W'(cmd_q.s);
      trial[i] = {rem_q[i], lq_q[i][ads_pkg::SAMPLE_BITS-1]};
      ge[i]    = (trial[i] >= {1'b0, den});
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = cmd_q.emit ? ST_REST : ST_IDLE;
      end
      ST_REST: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + ads_pkg::DIV_CNT_W'(1);
        if (cnt_q == ads_pkg::DIV_CNT_W'(ads_pkg::SAMPLE_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds a result until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Bin sums; a lane that is switched off keeps its sum until the row ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ads_pkg::LANES; i++) begin
        partial_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < ads_pkg::LANES; i++) begin
        if (state_q == ST_ACC && !cmd_q.emit) begin
          partial_q[i] <= cmd_q.last ? '0 : sum[i];
        end else if (state_q == ST_REST) begin
          if (cmd_q.last) begin
            partial_q[i] <= '0;
          end else if (cmd_q.act[i]) begin
            partial_q[i] <= prod_q[i];
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i) begin
      cmd_q <= pop_cmd_i;
    end
    for (int i = 0; i < ads_pkg::LANES; i++) begin
      if (state_q == ST_MUL || state_q == ST_ACC) begin
        prod_q[i] <= ads_pkg::SUM_W'(weight * cmd_q.smp[i]);
      end
      if (state_q == ST_ACC) begin
        sat_q[i] <= (num[i] >= (ads_pkg::NUM_W'(den) << ads_pkg::SAMPLE_BITS));
        rem_q[i] <= num[i][ads_pkg::NUM_W-1:ads_pkg::SAMPLE_BITS];
        lq_q[i]  <= num[i][ads_pkg::SAMPLE_BITS-1:0];
      end else if (state_q == ST_DIV) begin
        rem_q[i] <= ge[i] ? ads_pkg::DEN_W'(trial[i] - {1'b0, den})
                          : trial[i][ads_pkg::DEN_W-1:0];
        lq_q[i]  <= {lq_q[i][ads_pkg::SAMPLE_BITS-2:0], ge[i]};
      end
      if (load_out) begin
        if (!cmd_q.act[i]) begin
          res_q[i] <= '0;
        end else begin
          res_q[i] <= sat_q[i] ? '1 : lq_q[i];
        end
      end
    end
    if (load_out) begin
      row_end_q <= cmd_q.last;
    end
  end

  assign pix_o.valid   = out_valid_q;
  assign pix_o.out_0   = res_q[0];
  assign pix_o.out_1   = res_q[1];
  assign pix_o.out_2   = res_q[2];
  assign pix_o.out_3   = res_q[3];
  assign pix_o.row_end = row_end_q;

  `ASSERT_AT(a_result_loaded, clk_i, rst_ni, load_out |=> out_valid_q, "finished result not presented")
  `ASSERT_AT(a_row_clears_sums, clk_i, rst_ni, (state_q == ST_REST && cmd_q.last) |=> (partial_q[0] == '0), "bin sums not cleared at row end")

endmodule

/* rtl/core/area_downsample_horizontal_core.sv */
// Channel  | Direction | Transfer when        | Payload
// pix_i    | in        | valid && ready       | sample_0 .. sample_3
// pix_o    | out       | valid && ready       | out_0 .. out_3, row_end
// cfg      | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A pixel that stays inside its bin passes the back-end states IDLE, MUL and
// ACC; one that fills a bin goes on through REST, DIV and DONE, where the
// per-lane restoring divider produces one quotient bit per cycle.
// The front classifies one pixel per cycle into a four-entry command queue
// while it has room, so up to four pixels are taken while the back end works or a result waits.
// Reset is asynchronous and active low; it clears the row state, the queue
// and the output register, and sets all configuration registers to one.
`timescale 1ns / 1ps

module area_downsample_horizontal_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ads_in_if.sink                             pix_i,
  ads_out_if.source                          pix_o,
  input  logic                               cfg_we_i,
  input  logic [ads_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ads_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  ads_pkg::cfg_t  cfg_q;
  logic           push_valid, q_full, pop_valid, pop_ready;
  ads_pkg::cmd_t  push_cmd, pop_cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width         <= ads_pkg::CFG_DATA_W'(1);
      cfg_q.dst_width         <= ads_pkg::CFG_DATA_W'(1);
      cfg_q.samples_per_pixel <= ads_pkg::SPP_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ads_pkg::CFG_SRC_WIDTH: cfg_q.src_width <= cfg_data_i;
        ads_pkg::CFG_DST_WIDTH: cfg_q.dst_width <= cfg_data_i;
        ads_pkg::CFG_SPP: cfg_q.samples_per_pixel <= cfg_data_i[ads_pkg::SPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ads_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_i        (pix_i),
    .q_full_i     (q_full),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  ads_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ads_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_cmd_i    (pop_cmd),
    .pix_o        (pix_o)
  );

endmodule

/* tb/tb_area_downsample_horizontal_core.sv */
`timescale 1ns / 1ps

module tb_area_downsample_horizontal_core;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_PIXELS  = 1050;

  // The two-bit index leaves one code without a register behind it.
  localparam logic [ads_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    ads_pkg::sample_t [ads_pkg::LANES-1:0] smp;
  } source_pixel_t;

  typedef struct packed {
    ads_pkg::sample_t [ads_pkg::LANES-1:0] avg;
    logic                                  row_end;
  } avg_pixel_t;

  // Mirrors the row state and the register set, and holds the averaged pixels
  // still owed by the block, oldest first.
  class downsample_scoreboard;
    int unsigned     src_reg;
    int unsigned     dst_reg;
    int unsigned     spp_reg;
    int unsigned     bin_fill;
    int unsigned     row_pixels;
    longint unsigned lane_sum [ads_pkg::LANES];
    avg_pixel_t      owed_avgs [$];
    int unsigned     mismatches;
    int unsigned     avgs_checked;
    int unsigned     rows_closed;
    int unsigned     pixels_taken;
    int unsigned     reg_writes;

    function new();
      src_reg    = 1;
      dst_reg    = 1;
      spp_reg    = 1;
      bin_fill   = 0;
      row_pixels = 0;
      foreach (lane_sum[i]) lane_sum[i] = 0;
      mismatches   = 0;
      avgs_checked = 0;
      rows_closed  = 0;
      pixels_taken = 0;
      reg_writes   = 0;
    endfunction

    function void write_reg(logic [ads_pkg::CFG_IDX_W-1:0] idx,
                            logic [ads_pkg::CFG_DATA_W-1:0] value);
      reg_writes++;
      case (idx)
        ads_pkg::CFG_SRC_WIDTH: src_reg = value;
        ads_pkg::CFG_DST_WIDTH: dst_reg = value;
        ads_pkg::CFG_SPP:       spp_reg = value[ads_pkg::SPP_W-1:0];
        default: ;
      endcase
    endfunction

    // Spreads one source pixel over the current bin and, when the bin fills,
    // the next one; a full bin owes one rounded average.
    function void note_pixel(source_pixel_t px);
      int unsigned     s;
      int unsigned     d;
      int unsigned     lanes_on;
      int unsigned     part;
      int unsigned     rest;
      longint unsigned smp [ads_pkg::LANES];
      longint unsigned acc;
      longint unsigned q;
      bit              last;
      avg_pixel_t      avg;

      s = src_reg;
      if (s < 1) s = 1;
      if (s > ads_pkg::MAX_WIDTH) s = ads_pkg::MAX_WIDTH;
      d = dst_reg;
      if (d < 1) d = 1;
      if (d > s) d = s;
      lanes_on = spp_reg;
      if (lanes_on < 1) lanes_on = 1;
      if (lanes_on > ads_pkg::LANES) lanes_on = ads_pkg::LANES;

      pixels_taken++;
      for (int i = 0; i < ads_pkg::LANES; i++) smp[i] = (i < lanes_on) ? px.smp[i] : 0;
      last = (row_pixels + 1 >= s);

      if (bin_fill + d < s) begin
        for (int i = 0; i < ads_pkg::LANES; i++) lane_sum[i] += d * smp[i];
        bin_fill += d;
      end else begin
        // A bin already past full after a width change takes nothing more.
        part = (bin_fill >= s) ? 0 : s - bin_fill;
        rest = d - part;
        avg = '0;
        // Lanes that are switched off keep their sums until the row ends.
        for (int i = 0; i < ads_pkg::LANES; i++) begin
          if (i < lanes_on) begin
            acc = lane_sum[i] + part * smp[i];
            q = (2 * acc + s) / (2 * longint'(s));
            if (q > 16'hFFFF) q = 16'hFFFF;
            avg.avg[i] = q[ads_pkg::SAMPLE_BITS-1:0];
            lane_sum[i] = rest * smp[i];
          end
        end
        avg.row_end = last;
        bin_fill = rest;
        owed_avgs.push_back(avg);
      end

      if (last) begin
        bin_fill = 0;
        foreach (lane_sum[i]) lane_sum[i] = 0;
        row_pixels = 0;
      end else begin
        row_pixels++;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    task check_result(avg_pixel_t got);
      avg_pixel_t want;
      if (owed_avgs.size() == 0) begin
        report_mismatch("averaged pixel arrived while none was owed");
      end else begin
        want = owed_avgs.pop_front();
        avgs_checked++;
        if (want.row_end) rows_closed++;
        for (int i = 0; i < ads_pkg::LANES; i++) begin
          if (got.avg[i] !== want.avg[i])
            report_mismatch($sformatf("pixel %0d out_%0d: got %h, expected %h",
                                      avgs_checked, i, got.avg[i], want.avg[i]));
        end
        if (got.row_end !== want.row_end)
          report_mismatch($sformatf("pixel %0d row_end: got %b, expected %b",
                                    avgs_checked, got.row_end, want.row_end));
      end
    endtask

    function int unsigned pending();
      return owed_avgs.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ads_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ads_pkg::CFG_DATA_W-1:0] cfg_data_i;

  ads_in_if  pix_if ();
  ads_out_if avg_if ();

  area_downsample_horizontal_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .pix_o      (avg_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  downsample_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;
  int unsigned settings_used;

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic source_pixel_t make_pixel(ads_pkg::sample_t a, ads_pkg::sample_t b,
                                               ads_pkg::sample_t c, ads_pkg::sample_t d);
    source_pixel_t px;
    px.smp = {d, c, b, a};
    return px;
  endfunction

  // Extremes turn up often; the rest is uniform.
  function automatic ads_pkg::sample_t rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ads_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic source_pixel_t rand_pixel();
    return make_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endfunction

  // Offers one pixel, idling at random first, and returns at its transfer.
  task automatic send_pixel(source_pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.sample_0 <= px.smp[0];
    pix_if.sample_1 <= px.smp[1];
    pix_if.sample_2 <= px.smp[2];
    pix_if.sample_3 <= px.smp[3];
    do @(posedge clk_i); while (!pix_if.ready);
    sb.note_pixel(px);
  endtask

  // Holds the sender off until every owed average has come, then lets the
  // back end finish pixels that owe nothing.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ads_pkg::CFG_IDX_W-1:0] idx,
                           logic [ads_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  // Writes the whole register set once the block is idle.
  task automatic configure(int unsigned src, int unsigned dst, int unsigned spp);
    wait_idle();
    write_reg(ads_pkg::CFG_SRC_WIDTH, src[ads_pkg::CFG_DATA_W-1:0]);
    write_reg(ads_pkg::CFG_DST_WIDTH, dst[ads_pkg::CFG_DATA_W-1:0]);
    write_reg(ads_pkg::CFG_SPP, spp[ads_pkg::CFG_DATA_W-1:0]);
    write_reg(CFG_UNUSED, ads_pkg::CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned   random_sent;
    int unsigned   src;
    int unsigned   dst;
    int unsigned   row_len;
    int unsigned   count;
    int unsigned   phase;
    int unsigned   idle_by_phase  [4];
    int unsigned   stall_by_phase [4];

    idle_by_phase  = '{0, 53, 0, 9};
    stall_by_phase = '{0, 0, 53, 9};

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    pix_if.valid    = 1'b0;
    pix_if.sample_0 = '0;
    pix_if.sample_1 = '0;
    pix_if.sample_2 = '0;
    pix_if.sample_3 = '0;
    avg_if.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    idle_cycles     = 0;
    settings_used   = 0;
    sb = new();

    fork
      // Output side: random back-pressure and a check of every transfer.
      forever begin
        @(posedge clk_i);
        if (rst_ni && avg_if.valid && avg_if.ready)
          sb.check_result({avg_if.out_3, avg_if.out_2, avg_if.out_1, avg_if.out_0,
                           avg_if.row_end});
        avg_if.ready <= ($urandom_range(99) >= stall_pct);
      end
      // Watchdog on cycles with no transfer on either channel.
      forever begin
        @(posedge clk_i);
        if ((pix_if.valid && pix_if.ready) || (avg_if.valid && avg_if.ready))
          idle_cycles = 0;
        else
          idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles, %0d averages still owed",
                   idle_cycles, sb.pending());
          $display("tb_area_downsample_horizontal_core failed");
          $finish;
        end
      end
    join_none

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: one pixel per row and bin, only the first lane active.
    send_pixel(make_pixel(16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC));
    send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // Halves round up: two pixels into one bin.
    configure(2, 1, 4);
    send_pixel(make_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0000));
    send_pixel(make_pixel(16'h0002, 16'h0001, 16'h0000, 16'hFFFF));

    // Three pixels into two bins, the middle one straddling the boundary.
    configure(3, 2, 4);
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(make_pixel(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE));

    // Zero widths and zero lanes clamp to one.
    configure(0, 0, 0);
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // Oversized widths clamp to the maximum; lane count above four clamps.
    // The row is left open on purpose.
    configure(16383, 16383, 7);
    repeat (3) send_pixel(rand_pixel());

    // Width change in mid-row, then a narrower source: the bin is already
    // past full, takes nothing of the next pixel and saturates.
    configure(8, 3, 5);
    repeat (2) send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    configure(2, 2, 4);
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (2) send_pixel(rand_pixel());

    // Two active lanes; the others must read zero.
    configure(5, 3, 2);
    repeat (5) send_pixel(rand_pixel());

    // Random settings: mostly whole short rows, some wide partial rows and
    // some rows cut short before the next setting.
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      phase     = random_sent * 4 / RANDOM_PIXELS;
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(3))
          0:       src = ads_pkg::MAX_WIDTH;
          1:       src = 16383;
          2:       src = $urandom_range(1000, 16383);
          default: src = ads_pkg::MAX_WIDTH - 1;
        endcase
        dst = ($urandom_range(1) == 0) ? src : $urandom_range(0, 16383);
        configure(src, dst, $urandom_range(0, 16383));
        count = $urandom_range(8, 40);
      end else begin
        src = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 24);
        dst = $urandom_range(0, src + 3);
        configure(src, dst, $urandom_range(0, 16383));
        row_len = (src == 0) ? 1 : src;
        count = row_len * $urandom_range(1, 4);
        if ($urandom_range(7) == 0) count += $urandom_range(1, row_len);
      end
      repeat (count) begin
        send_pixel(rand_pixel());
        random_sent++;
      end
    end

    wait_idle();
    $display("Covered %0d source pixels under %0d register settings (%0d register writes).",
             sb.pixels_taken, settings_used, sb.reg_writes);
    $display("Checked %0d averaged pixels, %0d of them closing a row; %0d mismatches.",
             sb.avgs_checked, sb.rows_closed, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb_area_downsample_horizontal_core passed");
    else
      $display("tb_area_downsample_horizontal_core failed");
    $finish;
  end

endmodule
